### hw/rtl/hcrm_pkg.sv
package hcrm_pkg;

    // quotient bits resolved by the divider pipeline, one per stage
    localparam int Q_BITS = 8;
    // dividend / remainder width: 510*255 + 255 needs 17 bits
    localparam int REM_W  = 17;
    localparam int CFG_IDX_W = 3;

    localparam logic [7:0] HUE_SPAN    = 8'd180;
    localparam logic [8:0] HUE_OPEN_TOP = 9'd181;
    localparam logic [8:0] CLAMP_TOP   = 9'd256;
    localparam logic [6:0] HUE_TOL_ALL = 7'd89;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_HUE = 3'd0,
        REG_TARGET_SAT = 3'd1,
        REG_TARGET_VAL = 3'd2,
        REG_HUE_TOL    = 3'd3,
        REG_SAT_TOL    = 3'd4,
        REG_VAL_TOL    = 3'd5
    } cfg_reg_t;

    // which component holds the maximum; decides the hue offset
    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } sector_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        logic       in_range;
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] brightness;
    } result_t;

endpackage

### hw/rtl/hsv_color_range_mask.sv
// HSV color range mask.
// in_pixel (valid/ready) carries one BGR pixel word; out_result (valid/ready)
// returns one word per pixel: the mask bit and the HSV conversion.
// cfg_write/cfg_index/cfg_data write one of the six bound registers per cycle;
// the derived bounds follow in the next cycle. Write only while no pixel is in flight.
// An accepted pixel word travels to out_result and out_valid through the
// eleven register stages: one for max/min, one for the dividends, eight
// restoring-divide stages (one quotient bit each, saturation and hue divided
// side by side), one for the bound compare.
// Throughput is one pixel per cycle while out_ready is high; every stage carries
// its own valid bit, so a new pixel is taken whenever the first stage is empty or moving.
// When out_ready is low the stalled words stay in place and bubbles ahead of
// them are squeezed out; nothing is dropped or repeated.
// Reset empties the pipeline and loads the registers with target 0/0/0 and
// tolerances 36/102/127.
module hsv_color_range_mask
    import hcrm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pixel_t               in_pixel,
    output logic                 out_valid,
    input  logic                 out_ready,
    output result_t              out_result,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    typedef struct packed {
        logic [7:0] v;
        logic [7:0] d;
        logic [8:0] u;
        sector_t    sector;
    } a_stage_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem_s;
        logic [8:0]        div_s;
        logic [Q_BITS-1:0] q_s;
        logic [REM_W-1:0]  rem_h;
        logic [8:0]        div_h;
        logic [Q_BITS-1:0] q_h;
        logic [7:0]        v;
        logic              d_zero;
        sector_t           sector;
    } dv_stage_t;

    // configuration
    logic [7:0] target_hue_reg, target_sat_reg, target_val_reg;
    logic [6:0] hue_tol_reg;
    logic [7:0] sat_tol_reg, val_tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_hue_reg <= 8'd0;
            target_sat_reg <= 8'd0;
            target_val_reg <= 8'd0;
            hue_tol_reg    <= 7'd36;
            sat_tol_reg    <= 8'd102;
            val_tol_reg    <= 8'd127;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_TARGET_HUE: target_hue_reg <= cfg_data;
                REG_TARGET_SAT: target_sat_reg <= cfg_data;
                REG_TARGET_VAL: target_val_reg <= cfg_data;
                REG_HUE_TOL:    hue_tol_reg    <= cfg_data[6:0];
                REG_SAT_TOL:    sat_tol_reg    <= cfg_data;
                REG_VAL_TOL:    val_tol_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // bounds, registered from the config registers
    logic signed [9:0] hmin_next, hmax_next, hmin_reg, hmax_reg;
    logic [8:0] smin_next, smax_next, vmin_next, vmax_next;
    logic [8:0] smin_reg, smax_reg, vmin_reg, vmax_reg;
    logic signed [9:0] s_lo, v_lo;
    logic [8:0] s_hi, v_hi;

    always_comb
    begin
        hmin_next = $signed({2'b00, target_hue_reg}) - $signed({3'b000, hue_tol_reg});
        hmax_next = $signed({2'b00, target_hue_reg}) + $signed({3'b000, hue_tol_reg});
        if (hue_tol_reg > HUE_TOL_ALL)
        begin
            hmin_next = 10'sd0;
            hmax_next = $signed({1'b0, HUE_OPEN_TOP});
        end
        else
        begin
            if (hmin_next < 10'sd0)
                hmin_next = hmin_next + $signed({2'b00, HUE_SPAN});
            if (hmax_next > $signed({2'b00, HUE_SPAN}))
                hmax_next = hmax_next - $signed({2'b00, HUE_SPAN});
        end

        s_lo = $signed({2'b00, target_sat_reg}) - $signed({2'b00, sat_tol_reg});
        s_hi = {1'b0, target_sat_reg} + {1'b0, sat_tol_reg};
        v_lo = $signed({2'b00, target_val_reg}) - $signed({2'b00, val_tol_reg});
        v_hi = {1'b0, target_val_reg} + {1'b0, val_tol_reg};
        smin_next = s_lo[9] ? 9'd0 : s_lo[8:0];
        smax_next = s_hi[8] ? CLAMP_TOP : s_hi;
        vmin_next = v_lo[9] ? 9'd0 : v_lo[8:0];
        vmax_next = v_hi[8] ? CLAMP_TOP : v_hi;
    end

    always_ff @(posedge clk)
    begin
        hmin_reg <= hmin_next;
        hmax_reg <= hmax_next;
        smin_reg <= smin_next;
        smax_reg <= smax_next;
        vmin_reg <= vmin_next;
        vmax_reg <= vmax_next;
    end

    // per-stage flow control: a stage loads when it is empty or draining
    logic              a_vld_reg;
    logic [Q_BITS:0]   dv_vld_reg;
    logic              out_vld_reg;
    logic              a_free;
    logic [Q_BITS:0]   dv_free;
    logic              out_free;

    always_comb
    begin
        out_free = !out_vld_reg || out_ready;
        dv_free[Q_BITS] = !dv_vld_reg[Q_BITS] || out_free;
        for (int i = Q_BITS - 1; i >= 0; i--)
            dv_free[i] = !dv_vld_reg[i] || dv_free[i+1];
        a_free = !a_vld_reg || dv_free[0];
    end

    assign in_ready  = a_free;
    assign out_valid = out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            dv_vld_reg  <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (a_free)
                a_vld_reg <= in_valid;
            if (dv_free[0])
                dv_vld_reg[0] <= a_vld_reg;
            for (int i = 1; i <= Q_BITS; i++)
            begin
                if (dv_free[i])
                    dv_vld_reg[i] <= dv_vld_reg[i-1];
            end
            if (out_free)
                out_vld_reg <= dv_vld_reg[Q_BITS];
        end
    end

    // stage A: max, min, spread, sector and offset numerator u in [0, 2d]
    a_stage_t a_next, a_reg;
    logic [7:0] mx, mn;
    logic [9:0] u_wide;

    always_comb
    begin
        mx = in_pixel.red;
        if (in_pixel.green > mx) mx = in_pixel.green;
        if (in_pixel.blue > mx)  mx = in_pixel.blue;
        mn = in_pixel.red;
        if (in_pixel.green < mn) mn = in_pixel.green;
        if (in_pixel.blue < mn)  mn = in_pixel.blue;
        a_next.v = mx;
        a_next.d = mx - mn;
        if (mx == in_pixel.red)
        begin
            a_next.sector = SEC_RED;
            u_wide = {2'b00, in_pixel.green} + {2'b00, a_next.d} - {2'b00, in_pixel.blue};
        end
        else if (mx == in_pixel.green)
        begin
            a_next.sector = SEC_GREEN;
            u_wide = {2'b00, in_pixel.blue} + {2'b00, a_next.d} - {2'b00, in_pixel.red};
        end
        else
        begin
            a_next.sector = SEC_BLUE;
            u_wide = {2'b00, in_pixel.red} + {2'b00, a_next.d} - {2'b00, in_pixel.green};
        end
        a_next.u = u_wide[8:0];
    end

    always_ff @(posedge clk)
    begin
        if (a_free)
            a_reg <= a_next;
    end

    // stage B: dividends 510*d + v and 60*u + d, divisors 2v and 2d
    dv_stage_t dv_next [0:Q_BITS];
    dv_stage_t dv_reg  [0:Q_BITS];
    logic [REM_W-1:0] d_ext, u_ext, v_ext;

    always_comb
    begin
        d_ext = REM_W'(a_reg.d);
        u_ext = REM_W'(a_reg.u);
        v_ext = REM_W'(a_reg.v);
        dv_next[0].rem_s  = (d_ext << 9) - (d_ext << 1) + v_ext;
        dv_next[0].div_s  = {a_reg.v, 1'b0};
        dv_next[0].q_s    = '0;
        dv_next[0].rem_h  = (u_ext << 6) - (u_ext << 2) + d_ext;
        dv_next[0].div_h  = {a_reg.d, 1'b0};
        dv_next[0].q_h    = '0;
        dv_next[0].v      = a_reg.v;
        dv_next[0].d_zero = (a_reg.d == 8'd0);
        dv_next[0].sector = a_reg.sector;
    end

    // restoring divide, most significant quotient bit first
    for (genvar k = 0; k < Q_BITS; k++)
    begin : g_div
        localparam int SH = Q_BITS - 1 - k;
        logic [REM_W-1:0] sub_s, sub_h;
        logic [REM_W:0]   diff_s, diff_h;

        always_comb
        begin
            dv_next[k+1] = dv_reg[k];
            sub_s  = REM_W'(dv_reg[k].div_s) << SH;
            sub_h  = REM_W'(dv_reg[k].div_h) << SH;
            diff_s = {1'b0, dv_reg[k].rem_s} - {1'b0, sub_s};
            diff_h = {1'b0, dv_reg[k].rem_h} - {1'b0, sub_h};
            if (!diff_s[REM_W])
            begin
                dv_next[k+1].rem_s  = diff_s[REM_W-1:0];
                dv_next[k+1].q_s[SH] = 1'b1;
            end
            if (!diff_h[REM_W])
            begin
                dv_next[k+1].rem_h  = diff_h[REM_W-1:0];
                dv_next[k+1].q_h[SH] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i <= Q_BITS; i++)
        begin
            if (dv_free[i])
                dv_reg[i] <= dv_next[i];
        end
    end

    // final stage: hue offset, grey/black cases, bound compare
    dv_stage_t fin;
    logic [7:0] hue_next, sat_next;
    logic signed [9:0] h_s;
    logic [8:0] s_u, v_u;
    logic hue_ok;
    result_t out_next, out_reg;

    always_comb
    begin
        fin = dv_reg[Q_BITS];
        case (fin.sector)
            SEC_RED:
                hue_next = (fin.q_h < 8'd30) ? fin.q_h + 8'd150 : fin.q_h - 8'd30;
            SEC_GREEN:
                hue_next = fin.q_h + 8'd30;
            SEC_BLUE:
                hue_next = fin.q_h + 8'd90;
            default:
                hue_next = 8'd0;
        endcase
        if (fin.d_zero)
            hue_next = 8'd0;
        sat_next = (fin.v == 8'd0) ? 8'd0 : fin.q_s;

        h_s = $signed({2'b00, hue_next});
        s_u = {1'b0, sat_next};
        v_u = {1'b0, fin.v};
        // wrapped range is the union of [0, hmax) and [hmin, 181)
        if (hmin_reg <= hmax_reg)
            hue_ok = (h_s >= hmin_reg) && (h_s < hmax_reg);
        else
            hue_ok = (h_s < hmax_reg) ||
                     ((h_s >= hmin_reg) && (h_s < $signed({1'b0, HUE_OPEN_TOP})));

        out_next.in_range   = hue_ok && (s_u >= smin_reg) && (s_u < smax_reg)
                              && (v_u >= vmin_reg) && (v_u < vmax_reg);
        out_next.hue        = hue_next;
        out_next.saturation = sat_next;
        out_next.brightness = fin.v;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
            out_reg <= out_next;
    end

    assign out_result = out_reg;

endmodule

### dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hcrm_pkg::*;

    localparam int HALF_PERIOD      = 5;
    localparam int LATENCY          = 11;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int MAX_REPORTS      = 20;
    localparam int RANDOM_PHASES    = 10;
    localparam int PIXELS_PER_PHASE = 58;
    localparam int STREAM_PIXELS    = 150;

    // indexes past the last register; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    pixel_t               in_pixel;
    logic                 out_valid;
    logic                 out_ready;
    result_t              out_result;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    // shadow copy of the bound registers
    logic [7:0] tgt_hue;
    logic [7:0] tgt_sat;
    logic [7:0] tgt_val;
    logic [6:0] tol_hue;
    logic [7:0] tol_sat;
    logic [7:0] tol_val;

    result_t pending_results[$];
    int      errors;
    int      idle_cycles;
    bit      gaps_on;

    hsv_color_range_mask dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_pixel   (in_pixel),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (out_result),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    function automatic int div_floor(input int num, input int den);
        int q;
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic int clamp_bound(input int x);
        if (x < 0)
            return 0;
        if (x > 255)
            return int'(CLAMP_TOP);
        return x;
    endfunction

    function automatic result_t hsv_mask_of(input pixel_t px);
        int b, g, r, v, m, d, num, h, s;
        int hmin, hmax, smin, smax, vmin, vmax;
        bit hue_ok;
        result_t res;
        b = int'(px.blue);
        g = int'(px.green);
        r = int'(px.red);
        v = r;
        m = r;
        if (g > v) v = g;
        if (b > v) v = b;
        if (g < m) m = g;
        if (b < m) m = b;
        d = v - m;

        s = (v == 0) ? 0 : div_floor(510 * d + v, 2 * v);
        if (v == r)
            num = g - b;
        else if (v == g)
            num = b - r + 2 * d;
        else
            num = r - g + 4 * d;
        h = (d == 0) ? 0 : div_floor(60 * num + d, 2 * d);
        if (h < 0)
            h = h + int'(HUE_SPAN);

        hmin = int'(tgt_hue) - int'(tol_hue);
        hmax = int'(tgt_hue) + int'(tol_hue);
        if (int'(tol_hue) > int'(HUE_TOL_ALL))
        begin
            hmin = 0;
            hmax = int'(HUE_OPEN_TOP);
        end
        else
        begin
            if (hmin < 0) hmin = hmin + int'(HUE_SPAN);
            if (hmax > int'(HUE_SPAN)) hmax = hmax - int'(HUE_SPAN);
        end
        smin = clamp_bound(int'(tgt_sat) - int'(tol_sat));
        smax = clamp_bound(int'(tgt_sat) + int'(tol_sat));
        vmin = clamp_bound(int'(tgt_val) - int'(tol_val));
        vmax = clamp_bound(int'(tgt_val) + int'(tol_val));

        // wrapped hue range is the union of both ends
        if (hmin <= hmax)
            hue_ok = (h >= hmin) && (h < hmax);
        else
            hue_ok = (h < hmax) || (h >= hmin && h < int'(HUE_OPEN_TOP));

        res.in_range   = hue_ok && s >= smin && s < smax && v >= vmin && v < vmax;
        res.hue        = h[7:0];
        res.saturation = s[7:0];
        res.brightness = v[7:0];
        return res;
    endfunction

    function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        case (idx)
            REG_TARGET_HUE: tgt_hue = data;
            REG_TARGET_SAT: tgt_sat = data;
            REG_TARGET_VAL: tgt_val = data;
            REG_HUE_TOL:    tol_hue = data[6:0];
            REG_SAT_TOL:    tol_sat = data;
            REG_VAL_TOL:    tol_val = data;
            default: ;
        endcase
    endfunction

    // result check: oldest expectation against each accepted result word
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result word, expected none, got %h",
                             $time, out_result);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_result.in_range !== want.in_range ||
                    out_result.hue !== want.hue ||
                    out_result.saturation !== want.saturation ||
                    out_result.brightness !== want.brightness)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: mismatch expected in_range=%0b hue=%0d sat=%0d val=%0d",
                                 $time, want.in_range, want.hue, want.saturation,
                                 want.brightness,
                                 " actual in_range=%0b hue=%0d sat=%0d val=%0d",
                                 out_result.in_range, out_result.hue,
                                 out_result.saturation, out_result.brightness);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // receiver back-pressure in random bursts while gaps_on is set
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (gaps_on && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    task automatic send_pixel(input pixel_t px);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_pixel <= px;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_results.push_back(hsv_mask_of(px));
    endtask

    // sender holds off until every result word is back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        store_reg(idx, data);
    endtask

    task automatic apply_config(input logic [7:0] hue, input logic [7:0] sat,
                                input logic [7:0] val, input logic [7:0] htol,
                                input logic [7:0] stol, input logic [7:0] vtol);
        write_reg(REG_TARGET_HUE, hue);
        write_reg(REG_TARGET_SAT, sat);
        write_reg(REG_TARGET_VAL, val);
        write_reg(REG_HUE_TOL, htol);
        write_reg(REG_SAT_TOL, stol);
        write_reg(REG_VAL_TOL, vtol);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_hue_tol();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd89;
            2:       return 8'd90;
            3:       return 8'($urandom_range(128, 255));  // top bit is dropped
            default: return 8'($urandom_range(0, 60));
        endcase
    endfunction

    function automatic logic [7:0] pick_target_hue();
        case ($urandom_range(0, 6))
            0:       return 8'd0;
            1:       return 8'd180;
            2:       return 8'($urandom_range(181, 255));
            default: return 8'($urandom_range(0, 180));
        endcase
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t px;
        logic [7:0] level;
        px = pixel_t'(24'($urandom_range(0, 32'hFF_FFFF)));
        level = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
            0: px = pixel_t'{level, level, level};
            1:
            begin
                px.blue  = {8{px.blue[0]}};
                px.green = {8{px.green[0]}};
                px.red   = {8{px.red[0]}};
            end
            2: px.green = px.red;
            3: px.blue = px.green;
            default: ;
        endcase
        return px;
    endfunction

    // pixel words below are {blue, green, red}
    task automatic test_default_config();
        send_pixel(pixel_t'{8'd0, 8'd0, 8'd0});
        send_pixel(pixel_t'{8'd255, 8'd255, 8'd255});
        send_pixel(pixel_t'{8'd0, 8'd0, 8'd255});
        send_pixel(pixel_t'{8'd0, 8'd255, 8'd0});
        send_pixel(pixel_t'{8'd255, 8'd0, 8'd0});
        send_pixel(pixel_t'{8'd100, 8'd100, 8'd100});
        send_pixel(pixel_t'{8'd70, 8'd80, 8'd100});
        send_pixel(pixel_t'{8'd200, 8'd0, 8'd255});   // red max, negative hue
        send_pixel(pixel_t'{8'd255, 8'd255, 8'd0});
        send_pixel(pixel_t'{8'd0, 8'd255, 8'd255});
        send_pixel(pixel_t'{8'd0, 8'd0, 8'd1});
        send_pixel(pixel_t'{8'd1, 8'd2, 8'd3});
        wait_idle();
    endtask

    task automatic test_bound_cases();
        // hue tolerance beyond 89 opens all hues; sat/val top lands on 255
        apply_config(8'd200, 8'd200, 8'd200, 8'hFF, 8'd55, 8'd55);
        send_pixel(pixel_t'{8'd0, 8'd0, 8'd255});
        send_pixel(pixel_t'{8'd20, 8'd20, 8'd200});
        send_pixel(pixel_t'{8'd254, 8'd0, 8'd0});
        wait_idle();
        // hue window wraps past the top; sat/val clamp to 0 and 256
        apply_config(8'd170, 8'd128, 8'd255, 8'd30, 8'd255, 8'd255);
        send_pixel(pixel_t'{8'd0, 8'd0, 8'd255});
        send_pixel(pixel_t'{8'd200, 8'd0, 8'd255});
        send_pixel(pixel_t'{8'd0, 8'd255, 8'd0});
        wait_idle();
        // zero hue tolerance: empty window
        apply_config(8'd90, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255);
        send_pixel(pixel_t'{8'd255, 8'd255, 8'd0});
        send_pixel(pixel_t'{8'd128, 8'd128, 8'd128});
        send_pixel(pixel_t'{8'd0, 8'd128, 8'd0});
        wait_idle();
        // window wraps past the top
        apply_config(8'd180, 8'd255, 8'd255, 8'd89, 8'd255, 8'd255);
        send_pixel(pixel_t'{8'd0, 8'd0, 8'd0});
        send_pixel(pixel_t'{8'd255, 8'd0, 8'd0});
        send_pixel(pixel_t'{8'd0, 8'd128, 8'd255});
        wait_idle();
    endtask

    task automatic test_unused_index();
        write_reg(CFG_IDX_SPARE_LO, 8'hA5);
        write_reg(CFG_IDX_SPARE_HI, 8'h5A);
        cfg_write <= 1'b0;
        send_pixel(pixel_t'{8'd0, 8'd0, 8'd255});
        send_pixel(pixel_t'{8'd40, 8'd60, 8'd90});
        wait_idle();
    endtask

    task automatic test_random_configs();
        gaps_on = 1'b1;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            apply_config(pick_target_hue(), pick_byte(), pick_byte(),
                         pick_hue_tol(), pick_byte(), pick_byte());
            for (int i = 0; i < PIXELS_PER_PHASE; i++)
                send_pixel(rand_pixel());
            wait_idle();
        end
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        apply_config(pick_target_hue(), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(20, 89)),
                     8'($urandom_range(60, 255)), 8'($urandom_range(60, 255)));
        for (int i = 0; i < STREAM_PIXELS; i++)
            send_pixel(rand_pixel());
        wait_idle();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_pixel  = '0;
        out_ready = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        errors    = 0;
        gaps_on   = 1'b0;
        tgt_hue   = 8'd0;
        tgt_sat   = 8'd0;
        tgt_val   = 8'd0;
        tol_hue   = 7'd36;
        tol_sat   = 8'd102;
        tol_val   = 8'd127;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_config();
        test_bound_cases();
        test_unused_index();
        test_random_configs();
        test_back_to_back();

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
